// ===== hw/rtl/sse_pkg.sv =====
`default_nettype none

package sse_pkg;

    // default store depth
    localparam int CAPACITY_DEF = 16;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

    // read address select
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_IDX  = 2'd1;
    localparam logic [1:0] RD_PREV = 2'd2;
    localparam logic [1:0] RD_NEXT = 2'd3;

    typedef struct packed {
        logic       load;       // latch word value, clear index
        logic [1:0] rd_sel;     // memory read address
        logic       idx_inc;
        logic       idx_dec;
        logic       idx_to_cnt;
        logic       set_pos;    // pos <= idx, hit <= eq
        logic       clr_hit;    // pos <= idx, hit <= 0
        logic       wr_data;    // mem[idx] <= read data
        logic       wr_value;   // mem[idx] <= word value
        logic       cnt_inc;
        logic       cnt_dec;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_end;          // idx == count
        logic idx_at_pos;       // idx == pos
        logic idx_last;         // idx + 1 == count
        logic lt;               // entry below word value
        logic eq;               // entry equals word value
        logic hit;
        logic full;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hw/rtl/sse_datapath.sv =====
`default_nettype none

module sse_datapath #(
    parameter int CAPACITY = sse_pkg::CAPACITY_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic signed [sse_pkg::VALUE_W-1:0]   i_item_value,
    input  wire sse_pkg::t_dp_cmd                     i_cmd,
    output sse_pkg::t_dp_status                       o_status,
    output logic [sse_pkg::COUNT_W-1:0]               o_entry_count
);
    import sse_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CNTW = (CW > COUNT_W) ? CW : COUNT_W;

    logic signed [VALUE_W-1:0] r_mem [CAPACITY];
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] r_rdata;
    logic [CNTW-1:0]           r_idx;
    logic [CNTW-1:0]           r_pos;
    logic [CNTW-1:0]           r_count;
    logic                      r_hit;

    logic [CNTW-1:0] w_idx_prev;
    logic [CNTW-1:0] w_idx_next;
    logic [AW-1:0]   w_rd_addr;

    assign w_idx_prev = r_idx - CNTW'(1);
    assign w_idx_next = r_idx + CNTW'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PREV: w_rd_addr = w_idx_prev[AW-1:0];
            RD_NEXT: w_rd_addr = w_idx_next[AW-1:0];
            default: w_rd_addr = r_idx[AW-1:0];
        endcase
    end

    // entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_sel != RD_NONE) begin
            r_rdata <= r_mem[w_rd_addr];
        end
        if (i_cmd.wr_data) begin
            r_mem[r_idx[AW-1:0]] <= r_rdata;
        end else if (i_cmd.wr_value) begin
            r_mem[r_idx[AW-1:0]] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_item_value;
        end
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.idx_to_cnt) begin
            r_idx <= r_count;
        end else if (i_cmd.idx_inc) begin
            r_idx <= w_idx_next;
        end else if (i_cmd.idx_dec) begin
            r_idx <= w_idx_prev;
        end
        if (i_cmd.set_pos) begin
            r_pos <= r_idx;
            r_hit <= (r_rdata == r_value);
        end else if (i_cmd.clr_hit) begin
            r_pos <= r_idx;
            r_hit <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CNTW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CNTW'(1);
        end
    end

    assign o_status.idx_end    = (r_idx == r_count);
    assign o_status.idx_at_pos = (r_idx == r_pos);
    assign o_status.idx_last   = (w_idx_next == r_count);
    assign o_status.lt         = (r_rdata < r_value);
    assign o_status.eq         = (r_rdata == r_value);
    assign o_status.hit        = r_hit;
    assign o_status.full       = (r_count >= CNTW'(CAPACITY));

    assign o_entry_count = r_count[COUNT_W-1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_no_inc_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> !o_status.full)
        else $error("count raised on a full store");

endmodule

`default_nettype wire

// ===== hw/rtl/sse_control.sv =====
`default_nettype none

module sse_control (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic [sse_pkg::OPCODE_W-1:0]  i_opcode,
    input  wire sse_pkg::t_dp_status           i_status,
    output sse_pkg::t_dp_cmd                   o_cmd,
    output logic                               busy,
    output logic                               o_done,
    output logic                               o_success,
    output logic                               o_store_full
);
    import sse_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN_RD = 3'd1;
    localparam logic [2:0] S_SCAN_CM = 3'd2;
    localparam logic [2:0] S_DECIDE  = 3'd3;
    localparam logic [2:0] S_INS_CHK = 3'd4;
    localparam logic [2:0] S_INS_WR  = 3'd5;
    localparam logic [2:0] S_REM_CHK = 3'd6;
    localparam logic [2:0] S_REM_WR  = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [OPCODE_W-1:0] r_op, n_op;
    logic                r_ok, n_ok;
    logic                r_full, n_full;
    logic                r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_ok    = r_ok;
        n_full  = r_full;
        n_done  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_op       = i_opcode;
                    n_state    = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_status.idx_end) begin
                    o_cmd.clr_hit = 1'b1;
                    n_state       = S_DECIDE;
                end else begin
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = S_SCAN_CM;
                end
            end
            S_SCAN_CM: begin
                if (i_status.lt) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end else begin
                    o_cmd.set_pos = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_ok    = 1'b0;
                n_full  = 1'b0;
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_op)
                    OP_INSERT: begin
                        if (!i_status.hit && i_status.full) begin
                            n_full = 1'b1;
                        end else if (!i_status.hit) begin
                            o_cmd.idx_to_cnt = 1'b1;
                            n_done           = 1'b0;
                            n_state          = S_INS_CHK;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_status.hit) begin
                            n_done  = 1'b0;
                            n_state = S_REM_CHK;
                        end
                    end
                    OP_LOOKUP: begin
                        n_ok = i_status.hit;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            S_INS_CHK: begin
                if (i_status.idx_at_pos) begin
                    o_cmd.wr_value = 1'b1;
                    o_cmd.cnt_inc  = 1'b1;
                    n_ok           = 1'b1;
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.rd_sel = RD_PREV;
                    n_state      = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_data = 1'b1;
                o_cmd.idx_dec = 1'b1;
                n_state       = S_INS_CHK;
            end
            S_REM_CHK: begin
                if (i_status.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_ok          = 1'b1;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_REM_WR;
                end
            end
            S_REM_WR: begin
                o_cmd.wr_data = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_REM_CHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_op   <= n_op;
        r_ok   <= n_ok;
        r_full <= n_full;
    end

    // result word is shown in the first idle cycle after the operation
    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_success    = r_ok;
    assign o_store_full = r_full;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_ok_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_success && o_store_full))
        else $error("success and full flagged together");

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_set_engine_core.sv =====
`default_nettype none
// Timing: o_done rises once the scan compares and any entry moves for the word are done.
// Flow: one word at a time; busy stays high until the result is shown, paced by the
//   single registered read port of the entry memory.
// The result is on the o_ ports for exactly one cycle with o_done; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) empties the set and returns to idle; no clearing pass.

module sorted_set_engine_core #(
    parameter int CAPACITY = sse_pkg::CAPACITY_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [sse_pkg::OPCODE_W-1:0]         i_opcode,
    input  wire logic signed [sse_pkg::VALUE_W-1:0]   i_item_value,
    output logic                                      o_done,
    output logic                                      o_success,
    output logic                                      o_store_full,
    output logic [sse_pkg::COUNT_W-1:0]               o_entry_count
);
    import sse_pkg::*;

    // command and status between sequencer and store
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer: latches the opcode, walks the scan, then may shift entries up (insert) or
    // down (remove), each move a read state followed by a write state.
    sse_control u_control (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_opcode     (i_opcode),
        .i_status     (w_status),
        .o_cmd        (w_cmd),
        .busy         (busy),
        .o_done       (o_done),
        .o_success    (o_success),
        .o_store_full (o_store_full)
    );

    // Store: entry memory kept in ascending signed order, index/position
    // counters and the entry count. Only the lowest count entries are read.
    sse_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_value  (i_item_value),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire
